### rtl/rmq_pkg.sv
// Shared types, constants and width helpers for the rotation matrix to quaternion core.
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int VAL_W         = 17;
  localparam int Q_W           = 16;
  localparam int LANES         = 3;
  localparam int DIV_QBITS     = 16;

  localparam logic [Q_W-1:0] Q_POS_MAX = 16'h7FFF;
  localparam logic [Q_W-1:0] Q_NEG_MAX = 16'h8000;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_AXIS0 = 2'd1,
    BR_AXIS1 = 2'd2,
    BR_AXIS2 = 2'd3
  } rmq_branch_t;

  typedef struct packed {
    rmq_branch_t branch;
    logic        degen;
  } rmq_meta_t;

  // lane 0: w (or x on positive trace), lane 1: j axis, lane 2: k axis
  typedef struct packed {
    rmq_meta_t                     meta;
    logic [LANES-1:0][VAL_W-1:0]   v;
  } rmq_front_t;

  typedef struct packed {
    logic           neg;
    logic           ovf;
    logic [Q_W-1:0] q;
  } rmq_lane_t;

  // unsigned radicand width: 3 * 32767 + 2^f plus margin
  function automatic int rad_width(input int f);
    return (f + 2 > 18) ? f + 2 : 18;
  endfunction

endpackage

### rtl/rotation_matrix_to_quaternion_core.sv
// Top level: rotation matrix to unit quaternion, fully pipelined.
//
// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready  in_tdata: m00..m22, 16b signed each
// out_     out  out_tvalid/out_tready out_tdata: qx,qy,qz,qw; out_tuser: branch, degenerate
//
// One matrix per cycle in, one quaternion per cycle out, while out_tready does not stall the pipe.
// Stages: two front, one sqrt stage per root bit, 18 divider stages, the output register.
// Reset (rst_n low, synchronous) clears only the valid bits of every stage.
// A stall on out_tready freezes the whole pipe together; in_tready drops in that
// same cycle, so no beat is lost or repeated.
module rotation_matrix_to_quaternion_core #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // m00,m01,m02,m10,m11,m12,m20,m21,m22 from bit 0 up
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // qx,qy,qz,qw from bit 0 up
  output logic [2:0]   out_tuser   // branch_taken[1:0], degenerate[2]
);

  localparam int RAD_W  = rmq_pkg::rad_width(FRAC_BITS);
  localparam int ROOT_W = (RAD_W + FRAC_BITS + 1) / 2;
  localparam int NW     = 2 * ROOT_W;
  localparam int PW     = $bits(rmq_pkg::rmq_front_t);

  logic en;

  // whole pipe moves when the output register is free or being drained
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic                fr_valid;
  rmq_pkg::rmq_front_t fr_pay;
  logic [RAD_W-1:0]    fr_rad;

  rmq_front #(
    .FRAC_BITS (FRAC_BITS),
    .RAD_W     (RAD_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .out_valid (fr_valid),
    .out_pay   (fr_pay),
    .out_rad   (fr_rad)
  );

  logic                sq_valid;
  logic [ROOT_W-1:0]   sq_root;
  logic [PW-1:0]       sq_pay;
  logic [NW-1:0]       sq_rad;

  // radicand scaled so the root lands in the element format
  assign sq_rad = NW'(fr_rad) << FRAC_BITS;

  rmq_sqrt #(
    .ROOT_W (ROOT_W),
    .PW     (PW)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_rad    (sq_rad),
    .in_pay    (fr_pay),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_pay   (sq_pay)
  );

  logic                                    dv_valid;
  logic [ROOT_W-1:0]                       dv_root;
  rmq_pkg::rmq_meta_t                      dv_meta;
  rmq_pkg::rmq_lane_t [rmq_pkg::LANES-1:0] dv_lanes;

  rmq_div #(
    .FRAC_BITS (FRAC_BITS),
    .ROOT_W    (ROOT_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_pay    (rmq_pkg::rmq_front_t'(sq_pay)),
    .out_valid (dv_valid),
    .out_root  (dv_root),
    .out_meta  (dv_meta),
    .out_lanes (dv_lanes)
  );

  // output formatting: half root, lane saturation, axis placement
  logic [ROOT_W:0]  half_sum;
  logic [15:0]      half_q;
  logic [15:0]      lq [rmq_pkg::LANES];
  logic [15:0]      qx_nxt, qy_nxt, qz_nxt, qw_nxt;
  logic [63:0]      tdata_r;
  logic [2:0]       tuser_r;
  logic             tvalid_r;

  assign half_sum = ((ROOT_W+1)'(dv_root) + (ROOT_W+1)'(1)) >> 1;
  assign half_q   = (32'(half_sum) > 32'd32767) ? rmq_pkg::Q_POS_MAX : 16'(half_sum);

  always_comb begin
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      if (dv_lanes[l].neg) begin
        lq[l] = (dv_lanes[l].ovf || dv_lanes[l].q[15]) ? rmq_pkg::Q_NEG_MAX
                                                       : 16'(-dv_lanes[l].q);
      end else begin
        lq[l] = (dv_lanes[l].ovf || dv_lanes[l].q[15]) ? rmq_pkg::Q_POS_MAX
                                                       : dv_lanes[l].q;
      end
    end

    unique case (dv_meta.branch)
      rmq_pkg::BR_TRACE: begin
        qx_nxt = lq[0]; qy_nxt = lq[1]; qz_nxt = lq[2]; qw_nxt = half_q;
      end
      rmq_pkg::BR_AXIS0: begin
        qx_nxt = half_q; qy_nxt = lq[1]; qz_nxt = lq[2]; qw_nxt = lq[0];
      end
      rmq_pkg::BR_AXIS1: begin
        qx_nxt = lq[2]; qy_nxt = half_q; qz_nxt = lq[1]; qw_nxt = lq[0];
      end
      rmq_pkg::BR_AXIS2: begin
        qx_nxt = lq[1]; qy_nxt = lq[2]; qz_nxt = half_q; qw_nxt = lq[0];
      end
      default: begin
        qx_nxt = '0; qy_nxt = '0; qz_nxt = '0; qw_nxt = '0;
      end
    endcase

    // not a rotation: zero quaternion, branch still reported
    if (dv_meta.degen) begin
      qx_nxt = '0; qy_nxt = '0; qz_nxt = '0; qw_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= 1'b0;
    end else if (en) begin
      tvalid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tdata_r <= {qw_nxt, qz_nxt, qy_nxt, qx_nxt};
      tuser_r <= {dv_meta.degen, dv_meta.branch};
    end
  end

  assign out_tvalid = tvalid_r;
  assign out_tdata  = tdata_r;
  assign out_tuser  = tuser_r;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata == 64'd0)
    else $error("degenerate beat carries a nonzero quaternion");

  a_trace_not_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == rmq_pkg::BR_TRACE) |-> !out_tuser[2])
    else $error("positive trace beat flagged degenerate");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while the pipe is stalled");
`endif

endmodule

### rtl/rmq_front.sv
// Front end: trace, largest diagonal pick, radicand and the three lane operands.
module rmq_front #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int RAD_W     = rmq_pkg::rad_width(rmq_pkg::FRAC_BITS_DEF)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [143:0]        in_data,
  output logic                out_valid,
  output rmq_pkg::rmq_front_t out_pay,
  output logic [RAD_W-1:0]    out_rad
);

  localparam int RW1 = RAD_W + 1;

  logic signed [15:0] m_in [3][3];
  logic signed [15:0] m_r  [3][3];
  logic signed [17:0] trace_nxt, trace_r;
  logic [1:0]         axis_nxt, axis_r;
  logic               v1_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m_in[r][c] = in_data[(r*3+c)*16 +: 16];
      end
    end
  end

  always_comb begin
    logic signed [15:0] dsel;
    trace_nxt = 18'(m_in[0][0]) + 18'(m_in[1][1]) + 18'(m_in[2][2]);
    axis_nxt  = 2'd0;
    dsel      = m_in[0][0];
    if (m_in[1][1] > m_in[0][0]) begin
      axis_nxt = 2'd1;
      dsel     = m_in[1][1];
    end
    if (m_in[2][2] > dsel) begin
      axis_nxt = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r     <= m_in;
      trace_r <= trace_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // second stage
  logic signed [RW1-1:0] one_c, rad_s;
  logic signed [15:0]    mii, mjj, mkk;
  logic                  pos;
  rmq_pkg::rmq_front_t   pay_nxt, pay_r;
  logic [RAD_W-1:0]      rad_nxt, rad_r;
  logic                  v2_r;

  assign one_c = {{(RW1-1){1'b0}}, 1'b1} << FRAC_BITS;
  assign pos   = trace_r > 18'sd0;

  always_comb begin
    unique case (axis_r)
      2'd1: begin
        mii = m_r[1][1]; mjj = m_r[2][2]; mkk = m_r[0][0];
      end
      2'd2: begin
        mii = m_r[2][2]; mjj = m_r[0][0]; mkk = m_r[1][1];
      end
      default: begin
        mii = m_r[0][0]; mjj = m_r[1][1]; mkk = m_r[2][2];
      end
    endcase

    if (pos) begin
      rad_s = RW1'(trace_r) + one_c;
    end else begin
      rad_s = RW1'(mii) - RW1'(mjj) - RW1'(mkk) + one_c;
    end
    rad_nxt = (rad_s > 0) ? rad_s[RAD_W-1:0] : '0;

    pay_nxt.meta.degen = !pos && (rad_s <= 0);
    if (pos) begin
      pay_nxt.meta.branch = rmq_pkg::BR_TRACE;
      pay_nxt.v[0] = 17'(m_r[2][1]) - 17'(m_r[1][2]);
      pay_nxt.v[1] = 17'(m_r[0][2]) - 17'(m_r[2][0]);
      pay_nxt.v[2] = 17'(m_r[1][0]) - 17'(m_r[0][1]);
    end else begin
      unique case (axis_r)
        2'd1: begin
          pay_nxt.meta.branch = rmq_pkg::BR_AXIS1;
          pay_nxt.v[0] = 17'(m_r[0][2]) - 17'(m_r[2][0]);
          pay_nxt.v[1] = 17'(m_r[2][1]) + 17'(m_r[1][2]);
          pay_nxt.v[2] = 17'(m_r[0][1]) + 17'(m_r[1][0]);
        end
        2'd2: begin
          pay_nxt.meta.branch = rmq_pkg::BR_AXIS2;
          pay_nxt.v[0] = 17'(m_r[1][0]) - 17'(m_r[0][1]);
          pay_nxt.v[1] = 17'(m_r[0][2]) + 17'(m_r[2][0]);
          pay_nxt.v[2] = 17'(m_r[1][2]) + 17'(m_r[2][1]);
        end
        default: begin
          pay_nxt.meta.branch = rmq_pkg::BR_AXIS0;
          pay_nxt.v[0] = 17'(m_r[2][1]) - 17'(m_r[1][2]);
          pay_nxt.v[1] = 17'(m_r[1][0]) + 17'(m_r[0][1]);
          pay_nxt.v[2] = 17'(m_r[2][0]) + 17'(m_r[0][2]);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay_r <= pay_nxt;
      rad_r <= rad_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_pay   = pay_r;
  assign out_rad   = rad_r;

endmodule

### rtl/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage, payload carried along.
module rmq_sqrt #(
  parameter int ROOT_W = 16,
  parameter int PW     = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*ROOT_W-1:0] in_rad,
  input  logic [PW-1:0]       in_pay,
  output logic                out_valid,
  output logic [ROOT_W-1:0]   out_root,
  output logic [PW-1:0]       out_pay
);

  localparam int NW = 2 * ROOT_W;
  localparam int RW = ROOT_W + 2;

  logic              vld_r  [ROOT_W];
  logic [RW-1:0]     rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [NW-1:0]     rad_r  [ROOT_W];
  logic [PW-1:0]     pay_r  [ROOT_W];

  logic              vld_p  [ROOT_W];
  logic [RW-1:0]     rem_p  [ROOT_W];
  logic [ROOT_W-1:0] root_p [ROOT_W];
  logic [NW-1:0]     rad_p  [ROOT_W];
  logic [PW-1:0]     pay_p  [ROOT_W];
  logic [RW-1:0]     rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];

  always_comb begin
    for (int k = 0; k < ROOT_W; k++) begin
      logic [RW-1:0] rem_sh, trial;
      if (k == 0) begin
        vld_p[k]  = in_valid;
        rem_p[k]  = '0;
        root_p[k] = '0;
        rad_p[k]  = in_rad;
        pay_p[k]  = in_pay;
      end else begin
        vld_p[k]  = vld_r[k-1];
        rem_p[k]  = rem_r[k-1];
        root_p[k] = root_r[k-1];
        rad_p[k]  = rad_r[k-1];
        pay_p[k]  = pay_r[k-1];
      end
      rem_sh = {rem_p[k][RW-3:0], rad_p[k][NW-1-2*k -: 2]};
      trial  = {root_p[k], 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt[k]  = rem_sh - trial;
        root_nxt[k] = {root_p[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_sh;
        root_nxt[k] = {root_p[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ROOT_W; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < ROOT_W; k++) vld_r[k] <= vld_p[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_p[k];
        pay_r[k]  <= pay_p[k];
      end
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_pay   = pay_r[ROOT_W-1];

endmodule

### rtl/rmq_div.sv
// Three-lane pipelined restoring divider: round(v * 2^F / (2*S)), 16 quotient bits plus overflow.
module rmq_div #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int ROOT_W    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [ROOT_W-1:0]                   in_root,
  input  rmq_pkg::rmq_front_t                 in_pay,
  output logic                                out_valid,
  output logic [ROOT_W-1:0]                   out_root,
  output rmq_pkg::rmq_meta_t                  out_meta,
  output rmq_pkg::rmq_lane_t [rmq_pkg::LANES-1:0] out_lanes
);

  localparam int L    = rmq_pkg::LANES;
  localparam int QB   = rmq_pkg::DIV_QBITS;
  localparam int STG  = QB + 2;
  localparam int NUMW = rmq_pkg::VAL_W + FRAC_BITS + 1;
  localparam int CW   = (NUMW > ROOT_W + QB + 2) ? NUMW : ROOT_W + QB + 2;

  logic               vld_r  [STG];
  logic [ROOT_W-1:0]  root_r [STG];
  rmq_pkg::rmq_meta_t meta_r [STG];
  logic [CW-1:0]      rem_r  [L][STG];
  logic               neg_r  [L][STG];
  logic               ovf_r  [L][STG];
  logic [QB-1:0]      q_r    [L][STG];

  logic [CW-1:0]      rem_nxt [L][STG];
  logic               neg_nxt [L][STG];
  logic               ovf_nxt [L][STG];
  logic [QB-1:0]      q_nxt   [L][STG];

  always_comb begin
    for (int l = 0; l < L; l++) begin
      logic signed [rmq_pkg::VAL_W-1:0] v;
      logic [rmq_pkg::VAL_W-1:0]        mag;
      v   = $signed(in_pay.v[l]);
      mag = v[rmq_pkg::VAL_W-1] ? 17'(-v) : 17'(v);
      rem_nxt[l][0] = (CW'(mag) << FRAC_BITS) + CW'(in_root);
      neg_nxt[l][0] = v[rmq_pkg::VAL_W-1];
      ovf_nxt[l][0] = 1'b0;
      q_nxt[l][0]   = '0;

      rem_nxt[l][1] = rem_r[l][0];
      neg_nxt[l][1] = neg_r[l][0];
      ovf_nxt[l][1] = rem_r[l][0] >= (CW'({root_r[0], 1'b0}) << QB);
      q_nxt[l][1]   = '0;

      for (int s = 2; s < STG; s++) begin
        logic [CW-1:0] t;
        t = CW'({root_r[s-1], 1'b0}) << (STG - 1 - s);
        neg_nxt[l][s] = neg_r[l][s-1];
        ovf_nxt[l][s] = ovf_r[l][s-1];
        q_nxt[l][s]   = q_r[l][s-1];
        if (rem_r[l][s-1] >= t) begin
          rem_nxt[l][s] = rem_r[l][s-1] - t;
          q_nxt[l][s][STG-1-s] = 1'b1;
        end else begin
          rem_nxt[l][s] = rem_r[l][s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STG; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < STG; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r[0] <= in_root;
      meta_r[0] <= in_pay.meta;
      for (int s = 1; s < STG; s++) begin
        root_r[s] <= root_r[s-1];
        meta_r[s] <= meta_r[s-1];
      end
      for (int l = 0; l < L; l++) begin
        for (int s = 0; s < STG; s++) begin
          rem_r[l][s] <= rem_nxt[l][s];
          neg_r[l][s] <= neg_nxt[l][s];
          ovf_r[l][s] <= ovf_nxt[l][s];
          q_r[l][s]   <= q_nxt[l][s];
        end
      end
    end
  end

  assign out_valid = vld_r[STG-1];
  assign out_root  = root_r[STG-1];
  assign out_meta  = meta_r[STG-1];

  always_comb begin
    for (int l = 0; l < L; l++) begin
      out_lanes[l].neg = neg_r[l][STG-1];
      out_lanes[l].ovf = ovf_r[l][STG-1];
      out_lanes[l].q   = q_r[l][STG-1];
    end
  end

endmodule

### verif/tb_rotation_matrix_to_quaternion_core.sv
// Testbench for the rotation matrix to quaternion core: directed table plus random matrices.
`timescale 1ns / 100ps

module tb_rotation_matrix_to_quaternion_core;

  localparam int FRAC      = 14;
  localparam int ONE       = 1 << FRAC;
  localparam int N_RANDOM  = 800;
  localparam int N_QUIET   = 150;      // tail of the run without idling
  localparam int DRAIN     = 60;       // pipe is 37 deep at FRAC = 14
  localparam int HOLD_LEN  = 300;      // long receiver hold-off, fills the pipe
  localparam int LIMIT     = 400000;

  // one quaternion beat as seen on the result channel
  typedef struct {
    logic signed [15:0]   qx, qy, qz, qw;
    rmq_pkg::rmq_branch_t branch;
    logic                 degen;
  } quat_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;   // m00,m01,m02,m10,m11,m12,m20,m21,m22 from bit 0 up
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;  // qx,qy,qz,qw from bit 0 up
  logic [2:0]   out_tuser;  // branch_taken[1:0], degenerate[2]

  quat_t pending_quats[$];  // quaternions still owed by the core
  int    n_accepted;
  int    n_errors;
  int    cycles;
  bit    quiet;             // no idling on either side

  rotation_matrix_to_quaternion_core DUT (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic longint sat_q(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // floor of the square root, bit by bit
  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned acc;
    longint unsigned b;
    acc = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= acc + b) begin
        n   = n - (acc + b);
        acc = (acc >> 1) + b;
      end else begin
        acc = acc >> 1;
      end
      b = b >> 2;
    end
    return acc;
  endfunction

  // (v << FRAC) / (2*root), nearest, ties away from zero, then clamp
  function automatic longint root_ratio(longint v, longint unsigned root);
    longint unsigned mag, quo;
    longint          r;
    mag = (v < 0) ? -v : v;
    quo = ((mag << FRAC) + root) / (2 * root);
    r   = (quo > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : quo;
    return sat_q((v < 0) ? -r : r);
  endfunction

  function automatic quat_t matrix_to_quat(logic [143:0] flat);
    longint m[3][3];
    longint q[4];           // x, y, z, w
    longint trace, rad;
    longint unsigned root;
    int     i, j, k;
    quat_t  res;
    for (int e = 0; e < 9; e++) m[e / 3][e % 3] = $signed(flat[e*16 +: 16]);
    q = '{0, 0, 0, 0};
    res.degen = 1'b0;
    trace = m[0][0] + m[1][1] + m[2][2];
    if (trace > 0) begin
      res.branch = rmq_pkg::BR_TRACE;
      root = int_root(longint'(trace + ONE) << FRAC);
      q[3] = sat_q((root + 1) >> 1);
      q[0] = root_ratio(m[2][1] - m[1][2], root);
      q[1] = root_ratio(m[0][2] - m[2][0], root);
      q[2] = root_ratio(m[1][0] - m[0][1], root);
    end else begin
      // lower index wins on a tie
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      res.branch = rmq_pkg::rmq_branch_t'(i + 1);
      rad = m[i][i] - m[j][j] - m[k][k] + ONE;
      if (rad <= 0) begin
        res.degen = 1'b1;
      end else begin
        root = int_root(longint'(rad) << FRAC);
        q[i] = sat_q((root + 1) >> 1);
        q[3] = root_ratio(m[k][j] - m[j][k], root);
        q[j] = root_ratio(m[j][i] + m[i][j], root);
        q[k] = root_ratio(m[k][i] + m[i][k], root);
      end
    end
    res.qx = 16'(q[0]); res.qy = 16'(q[1]); res.qz = 16'(q[2]); res.qw = 16'(q[3]);
    return res;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic [143:0] pack_mat(int a00, int a01, int a02, int a10, int a11,
                                            int a12, int a20, int a21, int a22);
    logic [15:0] e[9];
    e = '{a00[15:0], a01[15:0], a02[15:0], a10[15:0], a11[15:0],
          a12[15:0], a20[15:0], a21[15:0], a22[15:0]};
    pack_mat = '0;
    for (int n = 0; n < 9; n++) pack_mat[n*16 +: 16] = e[n];
  endfunction

  // a genuine rotation from a random quaternion, rounded, with a little noise
  function automatic logic [143:0] random_rotation();
    real a, b, c, d, nrm;
    int  v[9];
    logic [143:0] flat;
    a = real'($urandom_range(0, 2000)) - 1000.0;
    b = real'($urandom_range(0, 2000)) - 1000.0;
    c = real'($urandom_range(0, 2000)) - 1000.0;
    d = real'($urandom_range(0, 2000)) - 1000.0;
    nrm = $sqrt(a*a + b*b + c*c + d*d) + 1.0e-9;
    a = a / nrm; b = b / nrm; c = c / nrm; d = d / nrm;
    v[0] = $rtoi((1.0 - 2.0*(c*c + d*d)) * ONE);
    v[1] = $rtoi(2.0*(b*c - a*d) * ONE);
    v[2] = $rtoi(2.0*(b*d + a*c) * ONE);
    v[3] = $rtoi(2.0*(b*c + a*d) * ONE);
    v[4] = $rtoi((1.0 - 2.0*(b*b + d*d)) * ONE);
    v[5] = $rtoi(2.0*(c*d - a*b) * ONE);
    v[6] = $rtoi(2.0*(b*d - a*c) * ONE);
    v[7] = $rtoi(2.0*(c*d + a*b) * ONE);
    v[8] = $rtoi((1.0 - 2.0*(b*b + c*c)) * ONE);
    flat = '0;
    for (int n = 0; n < 9; n++) begin
      v[n] = v[n] + int'($urandom_range(0, 6)) - 3;
      flat[n*16 +: 16] = v[n][15:0];
    end
    return flat;
  endfunction

  // drive one matrix and hold it until the core takes it
  task automatic send_matrix(logic [143:0] flat, quat_t want);
    in_tvalid <= 1'b1;
    in_tdata  <= flat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_quats.push_back(want);
    n_accepted++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // ---------------- directed table ----------------
  localparam int N_DIR = 14;
  logic [143:0] dir_mat[N_DIR];
  bit           dir_known[N_DIR];
  quat_t        dir_quat[N_DIR];

  initial begin
    quat_t z;
    z = '{qx: 0, qy: 0, qz: 0, qw: 0, branch: rmq_pkg::BR_TRACE, degen: 1'b0};
    dir_known = '{default: 1'b0};
    // identity: w = 0.5 * 2 = 1.0, root exactly 2^15
    dir_mat[0]  = pack_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
    dir_known[0] = 1; dir_quat[0] = z; dir_quat[0].qw = 16'sd16384;
    // all zero: trace not positive, tie keeps axis 0, root = 1.0
    dir_mat[1]  = pack_mat(0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_known[1] = 1; dir_quat[1] = z; dir_quat[1].qx = 16'sd8192;
    dir_quat[1].branch = rmq_pkg::BR_AXIS0;
    // 180 degrees about x, y, z: one axis per branch
    dir_mat[2]  = pack_mat(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE);
    dir_mat[3]  = pack_mat(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE);
    dir_mat[4]  = pack_mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE);
    // diagonal ties among the largest elements
    dir_mat[5]  = pack_mat(-100, 5, 7, 9, -100, 11, 13, 17, -200);
    dir_mat[6]  = pack_mat(-300, 5, 7, 9, -100, 11, 13, 17, -100);
    // trace of exactly zero goes to the axis branch, trace of one lsb does not
    dir_mat[7]  = pack_mat(1, 0, 0, 0, 0, 0, 0, 0, -1);
    dir_mat[8]  = pack_mat(1, 0, 0, 0, 0, 0, 0, 0, 0);
    // off-diagonal extremes push the divider into saturation both ways
    dir_mat[9]  = pack_mat(1, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0);
    dir_mat[10] = pack_mat(1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0);
    // diagonal at the positive and negative extremes
    dir_mat[11] = pack_mat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    dir_mat[12] = pack_mat(-32768, -32768, -32768, -32768, -32768, -32768,
                           -32768, -32768, -32768);
    dir_mat[13] = pack_mat(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768, -32768);
  end

  // ---------------- sender ----------------
  initial begin
    logic [143:0] flat;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    rst_n      <= 1'b0;
    n_accepted = 0;
    quiet      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++)
      send_matrix(dir_mat[r], dir_known[r] ? dir_quat[r] : matrix_to_quat(dir_mat[r]));

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_QUIET) quiet = 1'b1;
      if ($urandom_range(0, 9) < 6) begin
        flat = random_rotation();
      end else begin
        for (int e = 0; e < 9; e++) flat[e*16 +: 16] = 16'($urandom_range(0, 16'hFFFF));
      end
      send_matrix(flat, matrix_to_quat(flat));
    end
    in_tvalid <= 1'b0;

    while (pending_quats.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ---------------- receiver ----------------
  // Ready stays high at first; after 30 beats one long hold-off backs the
  // pipe up into the input, then random stall bursts until the quiet tail.
  initial begin
    out_tready <= 1'b1;
    while (n_accepted < 30) @(posedge clk);
    out_tready <= 1'b0;
    repeat (HOLD_LEN) @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 25)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------- checker ----------------
  always @(posedge clk) begin
    quat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_quats.size() == 0) begin
        $error("unexpected beat on out_: tdata=%h tuser=%h", out_tdata, out_tuser);
        n_errors++;
      end else begin
        want = pending_quats.pop_front();
        if (out_tdata[15:0] !== want.qx) begin
          $error("qx: expected %0d, got %0d", want.qx, $signed(out_tdata[15:0]));
          n_errors++;
        end
        if (out_tdata[31:16] !== want.qy) begin
          $error("qy: expected %0d, got %0d", want.qy, $signed(out_tdata[31:16]));
          n_errors++;
        end
        if (out_tdata[47:32] !== want.qz) begin
          $error("qz: expected %0d, got %0d", want.qz, $signed(out_tdata[47:32]));
          n_errors++;
        end
        if (out_tdata[63:48] !== want.qw) begin
          $error("qw: expected %0d, got %0d", want.qw, $signed(out_tdata[63:48]));
          n_errors++;
        end
        if (out_tuser[1:0] !== want.branch) begin
          $error("branch_taken: expected %0d, got %0d", want.branch, out_tuser[1:0]);
          n_errors++;
        end
        if (out_tuser[2] !== want.degen) begin
          $error("degenerate: expected %0b, got %0b", want.degen, out_tuser[2]);
          n_errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    n_errors = 0;
    cycles   = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
